// File: rtl/ssp_pkg.sv
// Shared types and constants for the SPI master serial port.
`timescale 1ns / 1ps
package ssp_pkg;
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] SEL_DATA   = 3'd0;
    localparam logic [2:0] SEL_STATUS = 3'd1;
    localparam logic [2:0] SEL_RAW    = 3'd2;
    localparam logic [2:0] SEL_MASKED = 3'd3;
    localparam logic [2:0] SEL_CLEAR  = 3'd4;

    localparam logic [2:0] CFG_PRESCALE = 3'd0;
    localparam logic [2:0] CFG_RATE     = 3'd1;
    localparam logic [2:0] CFG_PHASE    = 3'd2;
    localparam logic [2:0] CFG_POLARITY = 3'd3;
    localparam logic [2:0] CFG_DSS      = 3'd4;
    localparam logic [2:0] CFG_LOOPBACK = 3'd5;
    localparam logic [2:0] CFG_ENABLE   = 3'd6;
    localparam logic [2:0] CFG_IMASK    = 3'd7;

    // Classified word handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic        is_read;
        logic        is_write;
        logic [2:0]  sel;
        logic [15:0] wdata;
        logic        sin;
    } ssp_cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        serial_clock;
        logic        serial_out;
        logic        frame_select_n;
        logic        interrupt_out;
        logic        busy_res;
    } ssp_res_t;
endpackage

// File: rtl/spi_master_serial_port_top.sv
// Top level of the SPI master serial port.
`timescale 1ns / 1ps
// Usage:
// Each input word (op, reg_select, write_data, serial_in) is one peripheral
// tick, register read or register write. Push it while full is low. Each
// word yields exactly one result word (read_data and the serial pin levels),
// taken from the output queue with pop while empty is low.
// A two-entry command queue parts the decoder from the execution engine, and
// a two-entry result queue parts the engine from the receiver.
// Each word is registered in the command queue and executed by the engine, and
// its result is registered in the result queue, from which it is popped.
// Throughput: one word per cycle while the result queue is not full.
// When the receiver stops popping, the result queue fills, the engine stalls,
// then the command queue fills and full rises; nothing is lost.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while no word is in flight, which the block does not
// enforce. The bit period is registered in half_reg from prescale and rate.
// Reset clears FIFO counts, the shift engine, interrupt flags and registers
// to their defaults; FIFO payload storage is not cleared.
module spi_master_serial_port_top
    import ssp_pkg::*;
#(
    parameter int FIFO_DEPTH      = 8,
    parameter int TIMEOUT_PERIODS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [2:0]  reg_select,
    input  logic [15:0] write_data,
    input  logic        serial_in,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] read_data,
    output logic        serial_clock,
    output logic        serial_out,
    output logic        frame_select_n,
    output logic        interrupt_out,
    output logic        busy_res
);
    ssp_cmd_t cmd_in, cmd_q;
    ssp_res_t res, res_q;
    logic     cmd_empty, cmd_take, res_full, res_push;

    ssp_front u_front (
        .op(op), .reg_select(reg_select), .write_data(write_data),
        .serial_in(serial_in), .cmd(cmd_in)
    );

    ssp_queue #(.WIDTH($bits(ssp_cmd_t))) u_cmd_q (
        .clk(clk), .rst_n(rst_n), .push(push), .din(cmd_in), .full(full),
        .pop(cmd_take), .dout(cmd_q), .empty(cmd_empty)
    );

    ssp_back #(.FIFO_DEPTH(FIFO_DEPTH), .TIMEOUT_PERIODS(TIMEOUT_PERIODS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd_valid(!cmd_empty), .cmd(cmd_q),
        .cmd_take(cmd_take), .res_full(res_full), .res_push(res_push), .res(res)
    );

    ssp_queue #(.WIDTH($bits(ssp_res_t))) u_res_q (
        .clk(clk), .rst_n(rst_n), .push(res_push), .din(res), .full(res_full),
        .pop(pop), .dout(res_q), .empty(empty)
    );

    assign read_data      = res_q.read_data;
    assign serial_clock   = res_q.serial_clock;
    assign serial_out     = res_q.serial_out;
    assign frame_select_n = res_q.frame_select_n;
    assign interrupt_out  = res_q.interrupt_out;
    assign busy_res       = res_q.busy_res;
endmodule

// File: rtl/ssp_front.sv
// Front end: accepts input words, decodes them into commands for the queue.
`timescale 1ns / 1ps
module ssp_front
    import ssp_pkg::*;
(
    input  logic [1:0]  op,
    input  logic [2:0]  reg_select,
    input  logic [15:0] write_data,
    input  logic        serial_in,
    output ssp_cmd_t    cmd
);
    // Decode the operation code
    always_comb
    begin
        cmd.is_tick  = (op == OP_TICK);
        cmd.is_read  = (op == OP_READ);
        cmd.is_write = (op == OP_WRITE);
        cmd.sel      = reg_select;
        cmd.wdata    = write_data;
        cmd.sin      = serial_in;
    end
endmodule

// File: rtl/ssp_queue.sv
// Two-entry register queue used between stages.
`timescale 1ns / 1ps
module ssp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             rd_ptr_reg, wr_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

// File: rtl/ssp_back.sv
// Back end: executes ticks, register reads and writes; one command per cycle while the result queue is not full.
`timescale 1ns / 1ps
module ssp_back
    import ssp_pkg::*;
#(
    parameter int FIFO_DEPTH      = 8,
    parameter int TIMEOUT_PERIODS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        cmd_valid,
    input  ssp_cmd_t    cmd,
    output logic        cmd_take,
    input  logic        res_full,
    output logic        res_push,
    output ssp_res_t    res
);
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int TW = $clog2(TIMEOUT_PERIODS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] HALF_C  = CW'(FIFO_DEPTH / 2);
    localparam logic [TW-1:0] TMO_C   = TW'(TIMEOUT_PERIODS);

    // Configuration registers
    logic [7:0] prescale_reg, rate_reg;
    logic       phase_reg, polarity_reg, loop_reg, enable_reg;
    logic [3:0] dss_reg, imask_reg;

    // Engine state
    logic [15:0]   txf_reg [FIFO_DEPTH];
    logic [15:0]   rxf_reg [FIFO_DEPTH];
    logic [CW-1:0] tx_cnt_reg, rx_cnt_reg, tx_cnt_next, rx_cnt_next;
    logic [PW-1:0] tx_head_reg, rx_head_reg, tx_head_next, rx_head_next;
    logic [15:0]   shift_reg, shift_next;
    logic [4:0]    bit_cnt_reg, bit_cnt_next;
    logic [15:0]   pre_cnt_reg, pre_cnt_next;
    logic [1:0]    flags_reg, flags_next;
    logic [TW-1:0] idle_reg, idle_next;
    logic          sample_reg, sample_next;
    logic          tx_we, rx_we;
    logic [PW-1:0] tx_waddr, rx_waddr;
    logic [15:0]   rx_wdata;

    // Half period: max(prescale/2, 1)*(rate+1), registered since config is static
    logic [6:0]  pre_half;
    logic [15:0] half_reg, period;
    assign pre_half = (prescale_reg[7:1] == 7'd0) ? 7'd1 : prescale_reg[7:1];
    assign period   = {half_reg[14:0], 1'b0};

    logic [4:0] wlen;
    assign wlen = (dss_reg < 4'd3) ? 5'd4 : ({1'b0, dss_reg} + 5'd1);

    function automatic logic [PW-1:0] wrap(input logic [PW:0] i);
        logic [PW:0] r;
        r = (i >= (PW+1)'(FIFO_DEPTH)) ? i - (PW+1)'(FIFO_DEPTH) : i;
        return r[PW-1:0];
    endfunction

    function automatic logic outbit(input logic [15:0] s, input logic [4:0] l);
        logic [15:0] t;
        t = s >> (l - 5'd1);
        return t[0];
    endfunction

    assign cmd_take = cmd_valid && !res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 8'd2;
            rate_reg     <= 8'd0;
            phase_reg    <= 1'b0;
            polarity_reg <= 1'b0;
            dss_reg      <= 4'd7;
            loop_reg     <= 1'b0;
            enable_reg   <= 1'b0;
            imask_reg    <= 4'd0;
            half_reg     <= 16'd1;
        end
        else
        begin
            half_reg <= {9'd0, pre_half} * ({8'd0, rate_reg} + 16'd1);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PRESCALE: prescale_reg <= cfg_data;
                    CFG_RATE:     rate_reg     <= cfg_data;
                    CFG_PHASE:    phase_reg    <= cfg_data[0];
                    CFG_POLARITY: polarity_reg <= cfg_data[0];
                    CFG_DSS:      dss_reg      <= cfg_data[3:0];
                    CFG_LOOPBACK: loop_reg     <= cfg_data[0];
                    CFG_ENABLE:   enable_reg   <= cfg_data[0];
                    CFG_IMASK:    imask_reg    <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Execute one command
    logic [15:0] rdata;
    logic [3:0]  raw_i;
    logic        word_done;
    always_comb
    begin
        tx_cnt_next  = tx_cnt_reg;
        rx_cnt_next  = rx_cnt_reg;
        tx_head_next = tx_head_reg;
        rx_head_next = rx_head_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        pre_cnt_next = pre_cnt_reg;
        flags_next   = flags_reg;
        idle_next    = idle_reg;
        sample_next  = sample_reg;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        tx_waddr     = wrap({1'b0, tx_head_reg} + (PW+1)'(tx_cnt_reg));
        rx_waddr     = wrap({1'b0, rx_head_reg} + (PW+1)'(rx_cnt_reg));
        rx_wdata     = shift_reg;
        rdata        = 16'd0;
        word_done    = 1'b0;
        if (cmd.is_tick && enable_reg)
        begin
            if (bit_cnt_reg == 5'd0)
            begin
                if (tx_cnt_reg != '0)
                begin
                    shift_next   = txf_reg[tx_head_reg];
                    tx_head_next = wrap({1'b0, tx_head_reg} + 1'b1);
                    tx_cnt_next  = tx_cnt_reg - 1'b1;
                    bit_cnt_next = wlen;
                    pre_cnt_next = '0;
                    sample_next  = 1'b0;
                end
            end
            else
            begin
                pre_cnt_next = pre_cnt_reg + 16'd1;
                if (pre_cnt_next >= period)
                begin
                    pre_cnt_next = '0;
                    shift_next   = {shift_reg[14:0], sample_reg};
                    bit_cnt_next = bit_cnt_reg - 5'd1;
                    if (bit_cnt_next == 5'd0)
                    begin
                        word_done = 1'b1;
                        rx_wdata  = shift_next & 16'((17'd1 << wlen) - 17'd1);
                        if (rx_cnt_reg >= DEPTH_C)
                            flags_next[0] = 1'b1;
                        else
                        begin
                            rx_we       = 1'b1;
                            rx_cnt_next = rx_cnt_reg + 1'b1;
                        end
                        idle_next = '0;
                        if (tx_cnt_reg != '0)
                        begin
                            shift_next   = txf_reg[tx_head_reg];
                            tx_head_next = wrap({1'b0, tx_head_reg} + 1'b1);
                            tx_cnt_next  = tx_cnt_reg - 1'b1;
                            bit_cnt_next = wlen;
                            pre_cnt_next = '0;
                            sample_next  = 1'b0;
                        end
                    end
                end
                else if (pre_cnt_next == half_reg)
                begin
                    sample_next = loop_reg ? outbit(shift_reg, wlen) : cmd.sin;
                end
            end
            if (bit_cnt_next == 5'd0)
            begin
                if (rx_cnt_next == '0)
                begin
                    idle_next    = '0;
                    pre_cnt_next = '0;
                end
                else
                begin
                    pre_cnt_next = pre_cnt_next + 16'd1;
                    if (pre_cnt_next >= period)
                    begin
                        pre_cnt_next = '0;
                        if (idle_next < TMO_C) idle_next = idle_next + 1'b1;
                        if (idle_next >= TMO_C) flags_next[1] = 1'b1;
                    end
                end
            end
        end
        else if (cmd.is_read)
        begin
            case (cmd.sel)
                SEL_DATA:
                begin
                    if (rx_cnt_reg != '0)
                    begin
                        rdata        = rxf_reg[rx_head_reg];
                        rx_head_next = wrap({1'b0, rx_head_reg} + 1'b1);
                        rx_cnt_next  = rx_cnt_reg - 1'b1;
                        idle_next    = '0;
                        if (bit_cnt_reg == 5'd0) pre_cnt_next = '0;
                    end
                end
                SEL_STATUS:
                    rdata = {11'd0, (bit_cnt_reg != 5'd0) || (tx_cnt_reg != '0),
                             rx_cnt_reg >= DEPTH_C, rx_cnt_reg != '0,
                             tx_cnt_reg < DEPTH_C, tx_cnt_reg == '0};
                SEL_RAW:
                    rdata = {12'd0, tx_cnt_reg <= HALF_C, rx_cnt_reg >= HALF_C, flags_reg};
                SEL_MASKED:
                    rdata = {12'd0, imask_reg & {tx_cnt_reg <= HALF_C,
                                                 rx_cnt_reg >= HALF_C, flags_reg}};
                default: ;
            endcase
        end
        else if (cmd.is_write)
        begin
            if (cmd.sel == SEL_DATA)
            begin
                if (tx_cnt_reg < DEPTH_C)
                begin
                    tx_we       = 1'b1;
                    tx_cnt_next = tx_cnt_reg + 1'b1;
                end
            end
            else if (cmd.sel == SEL_CLEAR)
            begin
                flags_next = flags_reg & ~cmd.wdata[1:0];
            end
        end
        raw_i = {tx_cnt_next <= HALF_C, rx_cnt_next >= HALF_C, flags_next};
    end

    // Hold FIFO payloads
    always_ff @(posedge clk)
    begin
        if (cmd_take && tx_we) txf_reg[tx_waddr] <= cmd.wdata;
        if (cmd_take && rx_we) rxf_reg[rx_waddr] <= rx_wdata;
    end

    // Advance engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_cnt_reg  <= '0;
            rx_cnt_reg  <= '0;
            tx_head_reg <= '0;
            rx_head_reg <= '0;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            pre_cnt_reg <= '0;
            flags_reg   <= '0;
            idle_reg    <= '0;
            sample_reg  <= 1'b0;
        end
        else if (cmd_take)
        begin
            tx_cnt_reg  <= tx_cnt_next;
            rx_cnt_reg  <= rx_cnt_next;
            tx_head_reg <= tx_head_next;
            rx_head_reg <= rx_head_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            pre_cnt_reg <= pre_cnt_next;
            flags_reg   <= flags_next;
            idle_reg    <= idle_next;
            sample_reg  <= sample_next;
        end
    end

    // Form the result word from the post-command state
    logic active;
    always_comb
    begin
        active             = phase_reg ? (pre_cnt_next < half_reg)
                                       : (pre_cnt_next >= half_reg);
        res.read_data      = rdata;
        res.serial_clock   = polarity_reg;
        res.serial_out     = 1'b0;
        res.frame_select_n = 1'b1;
        if (enable_reg && bit_cnt_next != 5'd0)
        begin
            res.serial_clock   = polarity_reg ^ active;
            res.serial_out     = outbit(shift_next, wlen);
            res.frame_select_n = 1'b0;
        end
        res.interrupt_out = |(raw_i & imask_reg);
        res.busy_res      = (bit_cnt_next != 5'd0) || (tx_cnt_next != '0);
    end

    assign res_push = cmd_take;
endmodule
